// File: rtl/cars_pkg.sv
// ----------------------------------------------------------------------------
// cars_pkg
// shared constants and types of the cascaded attack/release smoother
// ----------------------------------------------------------------------------
package cars_pkg;

    localparam int STAGE_COUNT_DEF = 4;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int COEFF_BITS = 16;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;

    localparam logic REG_ATTACK  = 1'b0;
    localparam logic REG_RELEASE = 1'b1;

    localparam logic ACTION_PROCESS = 1'b0;
    localparam logic ACTION_CLEAR   = 1'b1;

    typedef struct packed {
        logic load;
        logic clear;
        logic diff;
        logic mul;
        logic upd;
        logic emit;
    } t_cmd;

endpackage

// File: rtl/cars_ctrl.sv
// ----------------------------------------------------------------------------
// cars_ctrl
// sequencer: steps each sample word through the stages, difference, multiply and update per stage
// ----------------------------------------------------------------------------
module cars_ctrl #(
    parameter int STAGE_COUNT = cars_pkg::STAGE_COUNT_DEF,
    parameter int SIDX_BITS   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_action,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cars_pkg::t_cmd       o_cmd,
    output logic [SIDX_BITS-1:0] o_stage
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [SIDX_BITS-1:0] LAST = SIDX_BITS'(STAGE_COUNT - 1);

    logic [2:0]           r_state, n_state;
    logic [SIDX_BITS-1:0] r_stage, n_stage;
    logic                 r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == cars_pkg::ACTION_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_stage    = '0;
                        n_state    = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_stage == LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_stage = r_stage + SIDX_BITS'(1);
                    n_state = S_DIFF;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_stage     = r_stage;

endmodule

// File: rtl/cars_dp.sv
// ----------------------------------------------------------------------------
// cars_dp
// stage levels, shared difference / multiply / round-and-update path
// ----------------------------------------------------------------------------
module cars_dp #(
    parameter int STAGE_COUNT = cars_pkg::STAGE_COUNT_DEF,
    parameter int SAMPLE_BITS = cars_pkg::SAMPLE_BITS_DEF,
    parameter int SIDX_BITS   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cars_pkg::t_cmd                      i_cmd,
    input  logic [SIDX_BITS-1:0]                i_stage,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic [cars_pkg::COEFF_BITS-1:0]     i_attack,
    input  logic [cars_pkg::COEFF_BITS-1:0]     i_release,
    output logic signed [SAMPLE_BITS-1:0]       o_envelope_out
);

    localparam int W  = SAMPLE_BITS;
    localparam int CB = cars_pkg::COEFF_BITS;
    localparam int DW = W + 1;
    localparam int PW = DW + CB + 1;
    localparam int YW = W + 2;

    localparam logic signed [PW-1:0] RND   = PW'(2 ** (CB - 1));
    localparam logic signed [YW-1:0] Y_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [YW-1:0] Y_MIN = {3'b111, {(W-1){1'b0}}};

    logic signed [W-1:0]  r_level [STAGE_COUNT];
    logic signed [W-1:0]  r_x;
    logic signed [DW-1:0] r_diff;
    logic [CB-1:0]        r_alpha;
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0]  r_out;

    logic signed [W-1:0]  w_level;
    logic signed [PW-1:0] w_sum;
    logic signed [YW-1:0] w_rnd;
    logic signed [YW-1:0] w_y;
    logic signed [W-1:0]  w_y_sat;

    assign w_level = r_level[i_stage];

    // floor((p + 2^15) / 2^16)
    assign w_sum = r_prod + RND;
    assign w_rnd = w_sum[CB +: YW];
    assign w_y   = YW'(r_x) + w_rnd;

    always_comb begin
        if (w_y > Y_MAX) begin
            w_y_sat = Y_MAX[W-1:0];
        end else if (w_y < Y_MIN) begin
            w_y_sat = Y_MIN[W-1:0];
        end else begin
            w_y_sat = w_y[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGE_COUNT; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cmd.clear) begin
            for (int i = 0; i < STAGE_COUNT; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_level[i_stage] <= w_y_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample_in;
        end else if (i_cmd.upd) begin
            r_x <= w_y_sat;
        end
        if (i_cmd.diff) begin
            r_diff  <= DW'(w_level) - DW'(r_x);
            r_alpha <= (r_x > w_level) ? i_attack : i_release;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_diff) * PW'($signed({1'b0, r_alpha}));
        end
        if (i_cmd.emit) begin
            r_out <= r_x;
        end
    end

    assign o_envelope_out = r_out;

endmodule

// File: rtl/cascaded_attack_release_smoother.sv
// ----------------------------------------------------------------------------
// cascaded_attack_release_smoother
// chain of one-pole attack/release smoothing stages on one shared datapath
// sample words are taken only while idle; a new one is not taken until the last
//   one's result has been emitted, as the single multiplier serves every stage in turn;
//   clear words are taken while idle and leave the block idle
// reset: synchronous active low, clears stage levels, coefficients, control
// ----------------------------------------------------------------------------
module cascaded_attack_release_smoother #(
    parameter int STAGE_COUNT = cars_pkg::STAGE_COUNT_DEF,
    parameter int SAMPLE_BITS = cars_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_envelope_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cars_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [cars_pkg::DATA_BITS-1:0]      pwdata,
    output logic [cars_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    localparam int SIDX_BITS = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int CB        = cars_pkg::COEFF_BITS;

    logic [CB-1:0]        r_attack;
    logic [CB-1:0]        r_release;
    logic                 w_wr;
    logic                 w_sel;
    cars_pkg::t_cmd       w_cmd;
    logic [SIDX_BITS-1:0] w_stage;

    assign pready = 1'b1;
    assign w_sel  = paddr[2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_release <= '0;
        end else if (w_wr) begin
            case (w_sel)
                cars_pkg::REG_ATTACK:  r_attack  <= pwdata[CB-1:0];
                cars_pkg::REG_RELEASE: r_release <= pwdata[CB-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            cars_pkg::REG_ATTACK:  prdata = cars_pkg::DATA_BITS'(r_attack);
            cars_pkg::REG_RELEASE: prdata = cars_pkg::DATA_BITS'(r_release);
            default:               prdata = '0;
        endcase
    end

    cars_ctrl #(
        .STAGE_COUNT (STAGE_COUNT),
        .SIDX_BITS   (SIDX_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .o_stage     (w_stage)
    );

    cars_dp #(
        .STAGE_COUNT (STAGE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SIDX_BITS   (SIDX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_stage        (w_stage),
        .i_sample_in    (i_sample_in),
        .i_attack       (r_attack),
        .i_release      (r_release),
        .o_envelope_out (o_envelope_out)
    );

    // a sample word keeps the block busy on the next cycle
    a_busy_after_sample : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == cars_pkg::ACTION_PROCESS) |=> !o_in_ready)
        else $error("block idle right after taking a sample word");

    // a clear word raises no result
    a_clear_no_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == cars_pkg::ACTION_CLEAR && !o_out_valid)
        |=> !o_out_valid)
        else $error("result word after a clear word");

    // a result only appears at the end of busy work
    a_result_after_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result word without preceding work");

endmodule
